>>> design/ccr_pkg.sv
package ccr_pkg;

  localparam int COLOR_W = 24;
  localparam int LUM_W = 17;
  localparam int RATIO_W = 17;
  localparam int PROD_W = 33;
  localparam int SUM_W = 34;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LUM_W-1:0] OFFSET_005 = 17'd3277;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 17'h1FFFF;

  // Q0.16 luminance weights, summing to exactly 1.0
  localparam logic [15:0] WEIGHT_R = 16'd13933;
  localparam logic [15:0] WEIGHT_G = 16'd46871;
  localparam logic [15:0] WEIGHT_B = 16'd4732;

  typedef logic [LUM_W-1:0] lum_t;

  typedef struct packed {
    lum_t first;
    lum_t second;
  } lum_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    VERDICT_GOOD    = 2'd0,
    VERDICT_WARNING = 2'd1,
    VERDICT_BAD     = 2'd2
  } verdict_t;

  typedef enum logic {
    REG_GOOD_THRESHOLD    = 1'b0,
    REG_WARNING_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef logic [255:0][LUM_W-1:0] gamma_rom_t;

  // sRGB decode to linear light, Q1.16, rounded to nearest
  function automatic gamma_rom_t build_gamma();
    gamma_rom_t rom;
    real x;
    real v;
    for (int c = 0; c < 256; c++) begin
      if (c * 100000 <= 4045 * 255) begin
        rom[c] = LUM_W'((13107200 * c + 329460) / 658920);
      end else begin
        x = (1000.0 * c + 14025.0) / 269025.0;
        v = (x ** 2.4) * 65536.0;
        rom[c] = LUM_W'($rtoi(v + 0.5));
      end
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

>>> design/ccr_front.sv
module ccr_front
  import ccr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] first_color,
  input  logic [COLOR_W-1:0] second_color,
  input  logic               in_valid,
  output logic               in_ready,
  output lum_pair_t          lum,
  output logic               push,
  input  queue_status_t      qstat
);

  logic v1, v2, v3;
  lum_t gam [6];
  logic [PROD_W-1:0] prod [6];
  logic [SUM_W-1:0] sum_first, sum_second;
  logic adv;

  // hold the whole front while the last beat cannot enter the queue
  assign adv = !v3 || !qstat.full;
  assign in_ready = adv;
  assign push = v3 && !qstat.full;

  assign sum_first = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(32768);
  assign sum_second = SUM_W'(prod[3]) + SUM_W'(prod[4]) + SUM_W'(prod[5]) + SUM_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      gam[0] <= GAMMA_ROM[first_color[23:16]];
      gam[1] <= GAMMA_ROM[first_color[15:8]];
      gam[2] <= GAMMA_ROM[first_color[7:0]];
      gam[3] <= GAMMA_ROM[second_color[23:16]];
      gam[4] <= GAMMA_ROM[second_color[15:8]];
      gam[5] <= GAMMA_ROM[second_color[7:0]];
      prod[0] <= PROD_W'(gam[0]) * PROD_W'(WEIGHT_R);
      prod[1] <= PROD_W'(gam[1]) * PROD_W'(WEIGHT_G);
      prod[2] <= PROD_W'(gam[2]) * PROD_W'(WEIGHT_B);
      prod[3] <= PROD_W'(gam[3]) * PROD_W'(WEIGHT_R);
      prod[4] <= PROD_W'(gam[4]) * PROD_W'(WEIGHT_G);
      prod[5] <= PROD_W'(gam[5]) * PROD_W'(WEIGHT_B);
      lum.first <= sum_first[32:16];
      lum.second <= sum_second[32:16];
    end
  end

endmodule

>>> design/ccr_queue.sv
module ccr_queue
  import ccr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lum_pair_t     wr_data,
  input  logic          pop,
  output lum_pair_t     rd_data,
  output queue_status_t qstat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lum_pair_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/ccr_back.sv
module ccr_back
  import ccr_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  lum_pair_t          head,
  input  queue_status_t      qstat,
  output logic               pop,
  input  logic [RATIO_W-1:0] good_threshold,
  input  logic [RATIO_W-1:0] warning_threshold,
  output logic [RATIO_W-1:0] contrast_ratio,
  output verdict_t           verdict,
  output lum_t               first_luminance,
  output lum_t               second_luminance,
  output logic               out_valid,
  input  logic               out_ready
);

  // ratio stays below 32, so five integer quotient bits suffice
  localparam int QW = RATIO_FRAC_BITS + 5;
  localparam int WW = (QW > RATIO_W) ? QW : RATIO_W;

  logic dv [QW+1];
  logic [QW-1:0] quo [QW+1];
  lum_pair_t lp [QW+1];
  lum_t rem [QW];
  lum_t na [QW];
  lum_t db [QW];

  logic adv;
  lum_t bright, dark;
  logic [WW-1:0] qwide;
  logic [RATIO_W-1:0] sat;
  verdict_t grade;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !qstat.empty;

  assign bright = (head.first > head.second) ? head.first : head.second;
  assign dark = (head.first > head.second) ? head.second : head.first;

  // load numerator, divisor and the partial remainder from the upper numerator bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= !qstat.empty;
      na[0] <= bright + OFFSET_005;
      db[0] <= dark + OFFSET_005;
      rem[0] <= LUM_W'((bright + OFFSET_005) >> 5);
      quo[0] <= '0;
      lp[0] <= head;
    end
  end

  // one restoring quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int P = QW - 1 - k;
    logic dbit;
    logic [LUM_W:0] trial;
    logic [LUM_W+1:0] diff;
    logic take;

    if (P >= RATIO_FRAC_BITS) begin : g_bit
      assign dbit = na[k][P-RATIO_FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign trial = {rem[k], dbit};
    assign diff = {1'b0, trial} - {2'b00, db[k]};
    assign take = !diff[LUM_W+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
        quo[k+1] <= {quo[k][QW-2:0], take};
        lp[k+1] <= lp[k];
      end
    end

    if (k < QW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          na[k+1] <= na[k];
          db[k+1] <= db[k];
          rem[k+1] <= take ? diff[LUM_W-1:0] : trial[LUM_W-1:0];
        end
      end
    end
  end

  assign qwide = WW'(quo[QW]);
  assign sat = (qwide > WW'(RATIO_MAX)) ? RATIO_MAX : qwide[RATIO_W-1:0];

  always_comb begin
    if (sat >= good_threshold) grade = VERDICT_GOOD;
    else if (sat >= warning_threshold) grade = VERDICT_WARNING;
    else grade = VERDICT_BAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QW];
      contrast_ratio <= sat;
      verdict <= grade;
      first_luminance <= lp[QW].first;
      second_luminance <= lp[QW].second;
    end
  end

endmodule

>>> design/color_contrast_ratio_grader.sv
// A beat passes the front-end registers, the queue, the divider and the output register.
// Throughput: one colour pair per cycle when no side stalls; the divider retires one
// quotient bit per stage, RATIO_FRAC_BITS + 5 stages deep, and a four-entry queue
// splits the luminance front end from the divider so each side stalls on its own.
// Reset clears all valid state and the queue, and loads the thresholds with 4.5 and 3.0.
module color_contrast_ratio_grader
  import ccr_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COLOR_W-1:0] first_color,
  input  logic [COLOR_W-1:0] second_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RATIO_W-1:0] contrast_ratio,
  output logic [1:0]         verdict,
  output logic [LUM_W-1:0]   first_luminance,
  output logic [LUM_W-1:0]   second_luminance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [RATIO_W-1:0] cfg_data
);

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

  logic [RATIO_W-1:0] good_threshold, warning_threshold;
  lum_pair_t front_lum, head;
  logic push, pop;
  queue_status_t qstat;
  verdict_t grade;

  assign cfg_ready = 1'b1;
  assign verdict = grade;

  always_ff @(posedge clk) begin
    if (rst) begin
      good_threshold <= 17'd18432;
      warning_threshold <= 17'd12288;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GOOD_THRESHOLD: good_threshold <= cfg_data;
        REG_WARNING_THRESHOLD: warning_threshold <= cfg_data;
      endcase
    end
  end

  ccr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .first_color  (first_color),
    .second_color (second_color),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .lum          (front_lum),
    .push         (push),
    .qstat        (qstat)
  );

  ccr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_lum),
    .pop     (pop),
    .rd_data (head),
    .qstat   (qstat)
  );

  ccr_back #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .good_threshold    (good_threshold),
    .warning_threshold (warning_threshold),
    .contrast_ratio    (contrast_ratio),
    .verdict           (grade),
    .first_luminance   (first_luminance),
    .second_luminance  (second_luminance),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

  // the brighter colour is always the dividend
  a_ratio_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> contrast_ratio >= RATIO_ONE)
    else $error("contrast ratio below one");

  a_equal_lum: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_luminance == second_luminance |-> contrast_ratio == RATIO_ONE)
    else $error("equal luminances must give a ratio of one");

  a_good_grade: assert property (@(posedge clk) disable iff (rst)
    out_valid && contrast_ratio >= good_threshold |-> verdict == VERDICT_GOOD)
    else $error("ratio above good threshold not graded good");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into a full queue");

endmodule

>>> tb/color_contrast_ratio_grader_tb.sv
`timescale 1ns / 1ps

module color_contrast_ratio_grader_tb;
  import ccr_pkg::*;

  localparam int FRAC_BITS = 12;
  localparam int LUM_FLOOR = 3277;        // 0.05 in Q1.16
  localparam int LONG_HOLD = 80;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = FRAC_BITS + 20;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [COLOR_W-1:0] first;
    logic [COLOR_W-1:0] second;
  } color_pair_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    verdict_t           grade;
    lum_t               first_lum;
    lum_t               second_lum;
  } pair_grade_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COLOR_W-1:0] first_color = '0;
  logic [COLOR_W-1:0] second_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RATIO_W-1:0] contrast_ratio;
  logic [1:0]         verdict;
  logic [LUM_W-1:0]   first_luminance;
  logic [LUM_W-1:0]   second_luminance;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_GOOD_THRESHOLD;
  logic [RATIO_W-1:0] cfg_data = '0;

  // sRGB decode table and the grader's thresholds as the block should hold them
  lum_t               linear_light [256];
  logic [RATIO_W-1:0] good_level = 17'd18432;
  logic [RATIO_W-1:0] warning_level = 17'd12288;

  color_pair_t pairs_to_send [$];
  pair_grade_t grades_due [$];

  bit in_beat;
  bit out_beat;
  bit cfg_beat;
  bit sender_eager;
  bit receiver_eager;
  int send_gap;
  int recv_hold;
  int stalls_asked;
  int stalls_served;
  int idle_cycles;
  int errors;
  int pairs_in;
  int grades_out;
  int cfg_writes;
  int settings_used;
  int input_stall_cycles;
  int verdict_count [3];
  color_pair_t next_pair;
  pair_grade_t want;

  color_contrast_ratio_grader #(
    .RATIO_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .first_color     (first_color),
    .second_color    (second_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .contrast_ratio  (contrast_ratio),
    .verdict         (verdict),
    .first_luminance (first_luminance),
    .second_luminance(second_luminance),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // Exact Q1.16 entry: linear segment up to code 10, else the largest R with
  // (2R-1)^5 * 269025^12 <= 2^85 * (1000c + 14025)^12.
  function automatic lum_t decode_channel(input int unsigned c);
    logic [383:0] num_pow;
    logic [383:0] den_pow;
    logic [383:0] lhs;
    logic [383:0] rhs;
    logic [383:0] odd;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (c <= 10) begin
      return lum_t'((13107200 * c + 329460) / 658920);
    end
    num_pow = 384'd1;
    den_pow = 384'd1;
    for (int k = 0; k < 12; k++) begin
      num_pow = num_pow * 384'(1000 * c + 14025);
      den_pow = den_pow * 384'd269025;
    end
    lhs = num_pow << 85;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 384'(2 * mid - 1);
      rhs = den_pow * odd * odd * odd * odd * odd;
      if (rhs <= lhs) lo = mid;
      else hi = mid - 1;
    end
    return lum_t'(lo);
  endfunction

  function automatic lum_t luminance_of(input logic [COLOR_W-1:0] rgb);
    logic [33:0] acc;
    acc = 34'd13933 * linear_light[rgb[23:16]] + 34'd46871 * linear_light[rgb[15:8]]
        + 34'd4732 * linear_light[rgb[7:0]];
    return lum_t'((acc + 34'd32768) >> 16);
  endfunction

  function automatic pair_grade_t grade_pair(input logic [COLOR_W-1:0] a,
                                             input logic [COLOR_W-1:0] b);
    pair_grade_t g;
    lum_t        bright;
    lum_t        dark;
    logic [33:0] quotient;
    g.first_lum = luminance_of(a);
    g.second_lum = luminance_of(b);
    bright = (g.first_lum > g.second_lum) ? g.first_lum : g.second_lum;
    dark = (g.first_lum > g.second_lum) ? g.second_lum : g.first_lum;
    quotient = ((34'(bright) + 34'(LUM_FLOOR)) << FRAC_BITS) / (34'(dark) + 34'(LUM_FLOOR));
    g.ratio = (quotient > 34'(RATIO_MAX)) ? RATIO_MAX : quotient[RATIO_W-1:0];
    // good is tested first, so it wins when the thresholds are out of order
    if (g.ratio >= good_level) g.grade = VERDICT_GOOD;
    else if (g.ratio >= warning_level) g.grade = VERDICT_WARNING;
    else g.grade = VERDICT_BAD;
    return g;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    logic [7:0] level;
    level = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: return {level, level, level};
      1: return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                 {8{1'($urandom_range(0, 1))}}};
      // codes around the knee between the linear and the power segment
      2: return {8'($urandom_range(8, 13)), 8'($urandom_range(8, 13)),
                 8'($urandom_range(8, 13))};
      default: return COLOR_W'($urandom());
    endcase
  endfunction

  function automatic color_pair_t pick_pair();
    color_pair_t p;
    p.first = pick_color();
    case ($urandom_range(0, 9))
      0: p.second = p.first;
      1: p.second = p.first ^ (24'd1 << $urandom_range(0, 23));
      default: p.second = pick_color();
    endcase
    if ($urandom_range(0, 1)) p = {p.second, p.first};
    return p;
  endfunction

  task automatic compare_field(input string what, input int unsigned expected,
                               input int unsigned actual);
    if (expected != actual) begin
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected,
                 actual);
      end
    end
  endtask

  task automatic queue_pair(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
    pairs_to_send.push_back({a, b});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pairs_to_send.size() != 0 || in_valid || grades_due.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [RATIO_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk);
    while (!cfg_beat);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [RATIO_W-1:0] good, input logic [RATIO_W-1:0] warn,
                           input int count, input bit eager_tx, input bit eager_rx);
    wait_idle();
    write_reg(REG_GOOD_THRESHOLD, good);
    write_reg(REG_WARNING_THRESHOLD, warn);
    settings_used++;
    sender_eager = eager_tx;
    receiver_eager = eager_rx;
    repeat (count) pairs_to_send.push_back(pick_pair());
  endtask

  // Sample every handshake, predict on input beats, check on output beats
  always @(posedge clk) begin
    in_beat = !rst && in_valid && in_ready;
    out_beat = !rst && out_valid && out_ready;
    cfg_beat = !rst && cfg_valid && cfg_ready;
    if (!rst && in_valid && !in_ready) input_stall_cycles++;
    if (cfg_beat) begin
      if (cfg_index == REG_GOOD_THRESHOLD) good_level = cfg_data;
      else warning_level = cfg_data;
      cfg_writes++;
    end
    if (in_beat) begin
      grades_due.push_back(grade_pair(first_color, second_color));
      pairs_in++;
    end
    if (out_beat) begin
      grades_out++;
      if (verdict < 2'd3) verdict_count[verdict]++;
      if (grades_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("%0t: result with nothing expected, expected none, actual ratio %0d",
                   $time, contrast_ratio);
        end
      end else begin
        want = grades_due.pop_front();
        compare_field("contrast_ratio", want.ratio, contrast_ratio);
        compare_field("verdict", want.grade, verdict);
        compare_field("first_luminance", want.first_lum, first_luminance);
        compare_field("second_luminance", want.second_lum, second_luminance);
      end
    end
  end

  // Sender: hold the beat until taken, then idle for the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_beat) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pairs_to_send.size() != 0) begin
        next_pair = pairs_to_send.pop_front();
        first_color <= next_pair.first;
        second_color <= next_pair.second;
        in_valid <= 1'b1;
        send_gap = sender_eager ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: draw a hold after each beat; a long hold on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_beat) recv_hold = receiver_eager ? 0 : $urandom_range(0, 4);
      if (stalls_served != stalls_asked) begin
        recv_hold = LONG_HOLD;
        stalls_served = stalls_asked;
      end
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               IDLE_LIMIT, grades_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int mark;
    for (int c = 0; c < 256; c++) linear_light[c] = decode_channel(c);
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed pairs under the reset thresholds
    settings_used = 1;
    queue_pair(24'h000000, 24'hFFFFFF);
    queue_pair(24'hFFFFFF, 24'h000000);
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'h000000, 24'h000000);
    queue_pair(24'h3C7A19, 24'h3C7A19);
    queue_pair(24'hFF0000, 24'h000000);
    queue_pair(24'h00FF00, 24'hFFFFFF);
    queue_pair(24'h0000FF, 24'hFFFFFF);
    queue_pair(24'h0A0A0A, 24'h0B0B0B);
    queue_pair(24'h0A0000, 24'h00000B);
    queue_pair(24'h777777, 24'hFFFFFF);
    queue_pair(24'h767676, 24'hFFFFFF);
    queue_pair(24'h808080, 24'hFFFFFF);
    queue_pair(24'h959595, 24'hFFFFFF);
    queue_pair(24'h808080, 24'hA0A0A0);
    queue_pair(24'hAAAAAA, 24'h555555);
    queue_pair(24'h555555, 24'hAAAAAA);
    queue_pair(24'h010101, 24'h000000);
    queue_pair(24'hFEFEFE, 24'hFFFFFF);
    queue_pair(24'hFF00FF, 24'h00FF00);
    queue_pair(24'h00FFFF, 24'hFF0000);
    queue_pair(24'h123456, 24'hEDCBA9);

    run_phase(17'd18432, 17'd12288, 300, 1'b0, 1'b0);
    // out of order: warning above good
    run_phase(17'd12288, 17'd18432, 150, 1'b0, 1'b1);
    run_phase(17'd86016, 17'd4096, 150, 1'b1, 1'b0);
    run_phase(17'd4096, 17'd86016, 100, 1'b0, 1'b0);
    run_phase(17'h1FFFF, 17'd0, 80, 1'b1, 1'b1);
    run_phase(17'd0, 17'h1FFFF, 80, 1'b0, 1'b0);

    // fill the block: sender keeps offering while the receiver holds off
    run_phase(17'd18432, 17'd12288, 220, 1'b1, 1'b1);
    mark = pairs_in;
    do @(negedge clk);
    while (pairs_in < mark + 8);
    stalls_asked++;

    run_phase(17'($urandom_range(4096, 86016)), 17'($urandom_range(4096, 86016)), 250,
              1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d colour pairs in, %0d graded, %0d threshold settings via %0d writes",
             pairs_in, grades_out, settings_used, cfg_writes);
    $display("verdicts good/warning/bad %0d/%0d/%0d; input held off for %0d cycles",
             verdict_count[0], verdict_count[1], verdict_count[2], input_stall_cycles);
    if (errors == 0 && grades_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
